// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Sizes, codes, types and rounding shared by the state-space step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dss_pkg;

  localparam int STATES  = 4;
  localparam int INPUTS  = 2;
  localparam int OUTPUTS = 2;

  localparam int VAL_W    = 24;
  localparam int FRAC_W   = 20;
  localparam int CMD_W    = 2;
  localparam int CIDX_W   = 6;
  localparam int Y_IDX_W  = 3;

  localparam int OFS_AD   = 0;
  localparam int OFS_BD   = OFS_AD + STATES * STATES;
  localparam int OFS_C    = OFS_BD + STATES * INPUTS;
  localparam int OFS_D    = OFS_C + OUTPUTS * STATES;
  localparam int COEF_USED = OFS_D + OUTPUTS * INPUTS;
  localparam int COEF_AW  = $clog2(COEF_USED);

  localparam int TERMS    = STATES + INPUTS;
  localparam int TERM_W   = $clog2(TERMS);
  localparam int MAX_ROWS = (STATES > OUTPUTS) ? STATES : OUTPUTS;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int STATE_IW = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int IN_IW    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int CNT_W    = $clog2(INPUTS + 1);

  localparam int PROD_W   = 2 * VAL_W;
  localparam int ACC_W    = PROD_W + TERM_W;
  localparam int QW       = ACC_W + 1 - FRAC_W;
  localparam int QMAX     = 8388607;
  localparam int QMIN     = -8388608;
  localparam logic signed [QW-1:0]    Q_HI = QW'(QMAX);
  localparam logic signed [QW-1:0]    Q_LO = QW'(QMIN);
  localparam logic signed [ACC_W:0]   ROUND_HALF = (ACC_W + 1)'(1 << (FRAC_W - 1));

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_COEF  = 2'd0,
    CMD_INPUT = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    K_COEF  = 2'd0,
    K_INPUT = 2'd1,
    K_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [COEF_AW-1:0]       idx;
    logic signed [VAL_W-1:0]  value;
    logic                     last;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qslot_t;

  function automatic logic signed [VAL_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W:0] t;
    logic signed [QW-1:0]  q;
    t = {acc[ACC_W-1], acc} + ROUND_HALF;
    q = t[ACC_W:FRAC_W];
    if (q > Q_HI) begin
      return VAL_W'(QMAX);
    end else if (q < Q_LO) begin
      return VAL_W'(QMIN);
    end
    return q[VAL_W-1:0];
  endfunction

endpackage

// ===== hdl/dss_if.sv =====
// ----------------------------------------------------------------------------
// dss request and result channels
// Valid/ready channels carrying one request or one output element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dss_in_if;
  logic                                valid;
  logic                                ready;
  logic [dss_pkg::CMD_W-1:0]           cmd;
  logic [dss_pkg::CIDX_W-1:0]          coef_index;
  logic signed [dss_pkg::VAL_W-1:0]    value;
  logic                                elem_last;

  modport source (output valid, cmd, coef_index, value, elem_last, input ready);
  modport sink   (input valid, cmd, coef_index, value, elem_last, output ready);
endinterface

interface dss_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dss_pkg::VAL_W-1:0]    y_value;
  logic [dss_pkg::Y_IDX_W-1:0]         y_index;
  logic                                y_last;

  modport source (output valid, y_value, y_index, y_last, input ready);
  modport sink   (input valid, y_value, y_index, y_last, output ready);
endinterface

// ===== hdl/dss_front.sv =====
// ----------------------------------------------------------------------------
// dss_front
// Accepts requests, decodes the command and forwards useful work to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dss_front (
  dss_in_if.sink          req,
  input  logic            push_ready,
  output dss_pkg::qslot_t push
);
  import dss_pkg::*;

  logic  keep;
  kind_t kind;

  always_comb begin
    keep = 1'b0;
    kind = K_INPUT;
    case (req.cmd)
      CMD_COEF: begin
        kind = K_COEF;
        keep = (int'(req.coef_index) < COEF_USED);
      end
      CMD_INPUT: begin
        kind = K_INPUT;
        keep = 1'b1;
      end
      CMD_CLEAR: begin
        kind = K_CLEAR;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign req.ready        = push_ready;
  assign push.valid       = req.valid && push_ready && keep;
  assign push.entry.kind  = kind;
  assign push.entry.idx   = COEF_AW'(req.coef_index);
  assign push.entry.value = req.value;
  assign push.entry.last  = req.elem_last;

endmodule

// ===== hdl/dss_queue.sv =====
// ----------------------------------------------------------------------------
// dss_queue
// Short FIFO of decoded requests between the front and the compute engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dss_queue (
  input  logic            clk,
  input  logic            rst,
  input  dss_pkg::qslot_t push,
  output logic            push_ready,
  output dss_pkg::qslot_t head,
  input  logic            pop_ready
);
  import dss_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QCNT_W-1:0]   cnt;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (cnt != QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push.valid;
  assign do_pop     = head.valid && pop_ready;
  assign head.valid = (cnt != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  `ASSERT_IMPLY(a_q_no_overflow, push.valid, cnt != QCNT_W'(QUEUE_DEPTH), "push into full queue")
  `ASSERT_ALWAYS(a_q_ptr_gap, (cnt == '0 || cnt == QCNT_W'(QUEUE_DEPTH)) || (wr_ptr != rd_ptr), "queue pointers disagree with fill count")

endmodule

// ===== hdl/dss_back.sv =====
// ----------------------------------------------------------------------------
// dss_back
// Executes queued requests: coefficient store, state clear, state update and output MAC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dss_back (
  input  logic            clk,
  input  logic            rst,
  input  dss_pkg::qslot_t head,
  output logic            pop_ready,
  dss_out_if.source       rsp
);
  import dss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_ISSUE_A = 5'b00010,
    S_WAIT_A  = 5'b00100,
    S_ISSUE_B = 5'b01000,
    S_WAIT_B  = 5'b10000
  } seq_t;

  seq_t seq;
  logic [ROW_W-1:0]  row;
  logic [TERM_W-1:0] term;

  logic signed [VAL_W-1:0] coef_mem [COEF_USED];
  logic [COEF_USED-1:0]    coef_vld;
  logic signed [VAL_W-1:0] state_vec [STATES];
  logic signed [VAL_W-1:0] nx [STATES];
  logic signed [VAL_W-1:0] in_buf [INPUTS];
  logic [CNT_W-1:0]        cnt;

  logic                    s1_valid, s1_first, s1_last, s1_phase_b, s1_cvld;
  logic [ROW_W-1:0]        s1_row;
  logic signed [VAL_W-1:0] s1_coef, s1_opnd;

  logic                     s2_valid, s2_first, s2_last, s2_phase_b;
  logic [ROW_W-1:0]         s2_row;
  logic signed [PROD_W-1:0] prod;

  logic signed [ACC_W-1:0] acc;
  logic                    done, done_phase_b;
  logic [ROW_W-1:0]        done_row;
  logic signed [VAL_W-1:0] result;

  logic                    out_valid;
  logic signed [VAL_W-1:0] y_value;
  logic [Y_IDX_W-1:0]      y_index;
  logic                    y_last;

  logic                    stall, issuing, phase_b, pop, commit, final_out;
  logic                    state_term;
  logic [COEF_AW-1:0]      iss_addr;
  logic signed [VAL_W-1:0] iss_opnd;
  logic [ROW_W-1:0]        row_max;

  assign stall     = done && done_phase_b && out_valid && !rsp.ready;
  assign phase_b   = (seq == S_ISSUE_B);
  assign issuing   = ((seq == S_ISSUE_A) || (seq == S_ISSUE_B)) && !stall;
  assign pop_ready = (seq == S_IDLE);
  assign pop       = head.valid && pop_ready;
  assign result    = round_sat(acc);
  assign commit    = done && !done_phase_b && (done_row == ROW_W'(STATES - 1));
  assign final_out = done && done_phase_b && (done_row == ROW_W'(OUTPUTS - 1)) && !stall;
  assign row_max   = phase_b ? ROW_W'(OUTPUTS - 1) : ROW_W'(STATES - 1);

  always_comb begin
    state_term = (term < TERM_W'(STATES));
    if (state_term) begin
      iss_opnd = state_vec[STATE_IW'(term)];
      iss_addr = (phase_b ? COEF_AW'(OFS_C) : COEF_AW'(OFS_AD))
               + COEF_AW'(row) * COEF_AW'(STATES) + COEF_AW'(term);
    end else begin
      iss_opnd = in_buf[IN_IW'(term - TERM_W'(STATES))];
      iss_addr = (phase_b ? COEF_AW'(OFS_D) : COEF_AW'(OFS_BD))
               + COEF_AW'(row) * COEF_AW'(INPUTS) + COEF_AW'(term)
               - COEF_AW'(STATES);
    end
  end

  // coefficient store with registered read
  always_ff @(posedge clk) begin
    if (pop && head.entry.kind == K_COEF) begin
      coef_mem[head.entry.idx] <= head.entry.value;
    end
    if (!stall) begin
      s1_coef <= coef_mem[iss_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (pop && head.entry.kind == K_COEF) begin
      coef_vld[head.entry.idx] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      seq  <= S_IDLE;
      row  <= '0;
      term <= '0;
    end else begin
      case (seq)
        S_IDLE: begin
          if (pop && head.entry.kind == K_INPUT && head.entry.last) begin
            seq  <= S_ISSUE_A;
            row  <= '0;
            term <= '0;
          end
        end
        S_ISSUE_A, S_ISSUE_B: begin
          if (!stall) begin
            if (term == TERM_W'(TERMS - 1)) begin
              term <= '0;
              if (row == row_max) begin
                seq <= (seq == S_ISSUE_A) ? S_WAIT_A : S_WAIT_B;
              end else begin
                row <= row + 1'b1;
              end
            end else begin
              term <= term + 1'b1;
            end
          end
        end
        S_WAIT_A: begin
          if (commit) begin
            seq  <= S_ISSUE_B;
            row  <= '0;
            term <= '0;
          end
        end
        S_WAIT_B: begin
          if (final_out) begin
            seq <= S_IDLE;
          end
        end
        default: begin
          seq <= S_IDLE;
        end
      endcase
    end
  end

  // state vector, next state and input buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STATES; i++) begin
        state_vec[i] <= '0;
      end
    end else if (pop && head.entry.kind == K_CLEAR) begin
      for (int i = 0; i < STATES; i++) begin
        state_vec[i] <= '0;
      end
    end else if (commit) begin
      for (int i = 0; i < STATES; i++) begin
        state_vec[i] <= (i == STATES - 1) ? result : nx[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done && !done_phase_b) begin
      nx[STATE_IW'(done_row)] <= result;
    end
    if (pop && head.entry.kind == K_INPUT && cnt < CNT_W'(INPUTS)) begin
      in_buf[IN_IW'(cnt)] <= head.entry.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (pop && head.entry.kind == K_INPUT) begin
      if (head.entry.last) begin
        cnt <= '0;
      end else if (cnt < CNT_W'(INPUTS)) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // MAC pipeline
  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_opnd    <= iss_opnd;
      s1_cvld    <= coef_vld[iss_addr];
      s1_first   <= (term == '0);
      s1_last    <= (term == TERM_W'(TERMS - 1));
      s1_phase_b <= phase_b;
      s1_row     <= row;
      prod       <= $signed(s1_cvld ? s1_coef : '0) * s1_opnd;
      s2_first   <= s1_first;
      s2_last    <= s1_last;
      s2_phase_b <= s1_phase_b;
      s2_row     <= s1_row;
      if (s2_valid) begin
        acc <= s2_first ? ACC_W'(prod) : acc + ACC_W'(prod);
      end
      done_phase_b <= s2_phase_b;
      done_row     <= s2_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else if (!stall) begin
      s1_valid <= issuing;
      s2_valid <= s1_valid;
      done     <= s2_valid && s2_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && done_phase_b && !stall) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && done_phase_b && !stall) begin
      y_value <= result;
      y_index <= Y_IDX_W'(done_row);
      y_last  <= (done_row == ROW_W'(OUTPUTS - 1));
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.y_value = y_value;
  assign rsp.y_index = y_index;
  assign rsp.y_last  = y_last;

  `ASSERT_IMPLY(a_commit_in_wait, commit, seq == S_WAIT_A, "state commit outside update drain")
  `ASSERT_IMPLY(a_idle_drained, seq == S_IDLE, !s1_valid && !s2_valid, "pipeline busy while idle")
  `ASSERT_ALWAYS(a_cnt_range, cnt <= CNT_W'(INPUTS), "input count beyond vector length")
  `ASSERT_IMPLY(a_stall_phase_b, stall, seq == S_ISSUE_B || seq == S_WAIT_B, "output stall outside output phase")

endmodule

// ===== hdl/discrete_state_space_step_top.sv =====
// ----------------------------------------------------------------------------
// discrete_state_space_step_top
// Coefficient, input and clear requests pass through a short queue. A last
// input element starts the update MAC pass over STATES rows of STATES+INPUTS
// terms, a drain, then the output MAC pass over OUTPUTS rows and another drain;
// no new request is popped until the last output element is registered.
// Synchronous reset invalidates coefficients, zeroes state and counts and empties the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module discrete_state_space_step_top (
  input  logic      clk,
  input  logic      rst,
  dss_in_if.sink    req,
  dss_out_if.source rsp
);
  import dss_pkg::*;

  qslot_t push;
  qslot_t head;
  logic   push_ready;
  logic   pop_ready;

  dss_front u_front (
    .req        (req),
    .push_ready (push_ready),
    .push       (push)
  );

  dss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop_ready  (pop_ready)
  );

  dss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop_ready (pop_ready),
    .rsp       (rsp)
  );

endmodule
